// File: sv/intel_hex_record_writer_unit_defines.svh
// ----------------------------------------------------------------------------
// Intel HEX record writer - assertion macros
// Concurrent check wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef INTEL_HEX_RECORD_WRITER_UNIT_DEFINES_SVH
`define INTEL_HEX_RECORD_WRITER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define IHRW_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("ihrw check failed");
// next-cycle implication
`define IHRW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("ihrw check failed");
`else
`define IHRW_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define IHRW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: sv/ihrw_pkg.sv
// ----------------------------------------------------------------------------
// Intel HEX record writer - package
// Request codes, character positions, job type and digit encoding.
// ----------------------------------------------------------------------------
`default_nettype none
package ihrw_pkg;

	localparam logic [1:0] REQ_DATA  = 2'd0;
	localparam logic [1:0] REQ_EMPTY = 2'd1;
	localparam logic [1:0] REQ_EOF   = 2'd2;

	// character slots within one request's run
	localparam logic [3:0] P_COLON   = 4'd0;
	localparam logic [3:0] P_LEN_HI  = 4'd1;
	localparam logic [3:0] P_LEN_LO  = 4'd2;
	localparam logic [3:0] P_AH_HI   = 4'd3;
	localparam logic [3:0] P_AH_LO   = 4'd4;
	localparam logic [3:0] P_AL_HI   = 4'd5;
	localparam logic [3:0] P_AL_LO   = 4'd6;
	localparam logic [3:0] P_TYPE_HI = 4'd7;
	localparam logic [3:0] P_TYPE_LO = 4'd8;
	localparam logic [3:0] P_DATA_HI = 4'd9;
	localparam logic [3:0] P_DATA_LO = 4'd10;
	localparam logic [3:0] P_CKS_HI  = 4'd11;
	localparam logic [3:0] P_CKS_LO  = 4'd12;
	localparam logic [3:0] P_CR      = 4'd13;
	localparam logic [3:0] P_LF      = 4'd14;

	localparam logic [6:0] CH_COLON = 7'h3A;
	localparam logic [6:0] CH_CR    = 7'h0D;
	localparam logic [6:0] CH_LF    = 7'h0A;
	localparam logic [6:0] CH_ZERO  = 7'h30;
	localparam logic [6:0] CH_ALPHA = 7'h37;

	localparam int JOB_DEPTH = 4;
	localparam int JOB_PTR_W = $clog2(JOB_DEPTH);
	localparam int JOB_CNT_W = $clog2(JOB_DEPTH + 1);

	typedef struct packed {
		logic        has_hdr;
		logic [7:0]  hdr_len;
		logic [15:0] hdr_addr;
		logic        hdr_eof;
		logic        has_data;
		logic [7:0]  data;
		logic        has_tail;
		logic [7:0]  cks;
		logic        err;
		logic [15:0] shown;
	} job_t;

	typedef struct packed {
		logic                 full;
		logic                 empty;
		logic [JOB_CNT_W-1:0] count;
	} fifo_status_t;

	typedef struct packed {
		logic job_pop;
		logic char_load;
		logic char_last;
	} back_status_t;

	function automatic logic [6:0] hex_char(input logic [3:0] nib);
		logic [6:0] wide;
		wide = {3'b000, nib};
		return (nib < 4'd10) ? 7'(CH_ZERO + wide) : 7'(CH_ALPHA + wide);
	endfunction

endpackage
`default_nettype wire

// File: sv/ihrw_front.sv
// ----------------------------------------------------------------------------
// Intel HEX record writer - front end
// Tracks the open record and turns each request into a character job.
// ----------------------------------------------------------------------------
`default_nettype none
module ihrw_front import ihrw_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        accept,
	input  wire logic [1:0]  req_type,
	input  wire logic [15:0] record_address,
	input  wire logic [7:0]  record_length,
	input  wire logic [7:0]  data_byte,
	output logic             job_push,
	output job_t             job
);

	logic [7:0]  bp_q, lat_q, sum_q;
	logic [15:0] cnt_q;
	logic [7:0]  bp_d, lat_d, sum_d;
	logic [15:0] cnt_d, cnt_inc;
	logic        first;
	logic [7:0]  addr_sum, base_sum, new_sum, new_bp, lat_use;

	assign first    = (bp_q == 8'd0);
	assign addr_sum = 8'(record_address[15:8] + record_address[7:0]);
	assign base_sum = first ? 8'(record_length + addr_sum) : sum_q;
	assign new_sum  = 8'(base_sum + data_byte);
	assign new_bp   = 8'(bp_q + 8'd1);
	assign lat_use  = first ? record_length : lat_q;
	assign cnt_inc  = 16'(cnt_q + 16'd1);

	always_comb begin
		bp_d          = bp_q;
		lat_d         = lat_q;
		sum_d         = sum_q;
		cnt_d         = cnt_q;
		job_push      = 1'b0;
		job           = '0;
		job.hdr_addr  = record_address;
		job.data      = data_byte;
		job.err       = !first;
		case (req_type)
			REQ_DATA: begin
				job_push = accept;
				job.err  = 1'b0;
				if (first && record_length == 8'd0) begin
					// zero length: empty record, byte dropped
					job.has_hdr  = 1'b1;
					job.has_tail = 1'b1;
					job.cks      = 8'(8'd0 - addr_sum);
					cnt_d        = cnt_inc;
				end else begin
					job.has_hdr  = first;
					job.hdr_len  = record_length;
					job.has_data = 1'b1;
					job.cks      = 8'(8'd0 - new_sum);
					if (new_bp >= lat_use) begin
						job.has_tail = 1'b1;
						cnt_d        = cnt_inc;
						bp_d         = 8'd0;
						lat_d        = 8'd0;
						sum_d        = 8'd0;
					end else begin
						bp_d  = new_bp;
						lat_d = lat_use;
						sum_d = new_sum;
					end
				end
				job.shown = cnt_d;
			end
			REQ_EMPTY: begin
				job_push     = accept;
				job.has_hdr  = 1'b1;
				job.has_tail = 1'b1;
				job.cks      = 8'(8'd0 - addr_sum);
				bp_d         = 8'd0;
				lat_d        = 8'd0;
				sum_d        = 8'd0;
				cnt_d        = cnt_inc;
				job.shown    = cnt_inc;
			end
			REQ_EOF: begin
				job_push     = accept;
				job.has_hdr  = 1'b1;
				job.hdr_addr = 16'd0;
				job.hdr_eof  = 1'b1;
				job.has_tail = 1'b1;
				job.cks      = 8'hFF;
				bp_d         = 8'd0;
				lat_d        = 8'd0;
				sum_d        = 8'd0;
				cnt_d        = 16'd0;
				job.shown    = cnt_q;
			end
			default: begin
				// unknown request: drop
				job_push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bp_q  <= 8'd0;
			lat_q <= 8'd0;
			sum_q <= 8'd0;
			cnt_q <= 16'd0;
		end else if (accept) begin
			bp_q  <= bp_d;
			lat_q <= lat_d;
			sum_q <= sum_d;
			cnt_q <= cnt_d;
		end
	end

endmodule
`default_nettype wire

// File: sv/ihrw_job_fifo.sv
// ----------------------------------------------------------------------------
// Intel HEX record writer - job queue
// Short queue between the front end and the character sequencer.
// ----------------------------------------------------------------------------
`default_nettype none
module ihrw_job_fifo import ihrw_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  wr_en,
	input  wire job_t  wr_job,
	input  wire logic  rd_en,
	output job_t       rd_job,
	output fifo_status_t status
);

	job_t                 mem_q [JOB_DEPTH];
	logic [JOB_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [JOB_CNT_W-1:0] cnt_q;
	logic                 do_wr, do_rd;

	assign status.full  = (cnt_q == JOB_CNT_W'(JOB_DEPTH));
	assign status.empty = (cnt_q == '0);
	assign status.count = cnt_q;
	assign do_wr        = wr_en && !status.full;
	assign do_rd        = rd_en && !status.empty;
	assign rd_job       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= JOB_PTR_W'(wr_ptr_q + 1'b1);
			end
			if (do_rd) begin
				rd_ptr_q <= JOB_PTR_W'(rd_ptr_q + 1'b1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= JOB_CNT_W'(cnt_q + 1'b1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= JOB_CNT_W'(cnt_q - 1'b1);
			end
		end
	end

endmodule
`default_nettype wire

// File: sv/ihrw_back.sv
// ----------------------------------------------------------------------------
// Intel HEX record writer - character sequencer
// Walks the slots of the head job into the result register, one character
// a cycle while the result register is empty or being popped.
// ----------------------------------------------------------------------------
`default_nettype none
module ihrw_back import ihrw_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   job_valid,
	input  wire job_t   job,
	input  wire logic   pop,
	output logic        empty,
	output logic [6:0]  ascii_char,
	output logic        last_of_run,
	output logic        order_error,
	output logic [15:0] records_written,
	output back_status_t status
);

	logic       busy_q;
	logic [3:0] pos_q;
	logic       out_valid_q;
	logic [3:0] start_pos, cur_pos, next_pos;
	logic       advance, load, last;
	logic [3:0] nib;
	logic [6:0] ch;

	assign start_pos = job.has_hdr ? P_COLON : (job.has_data ? P_DATA_HI : P_CKS_HI);
	assign cur_pos   = busy_q ? pos_q : start_pos;
	assign advance   = !out_valid_q || pop;
	assign load      = job_valid && advance;
	assign last      = (cur_pos == P_LF) || (cur_pos == P_DATA_LO && !job.has_tail);

	assign status.job_pop   = load && last;
	assign status.char_load = load;
	assign status.char_last = last;
	assign empty            = !out_valid_q;

	always_comb begin
		case (cur_pos)
			P_TYPE_LO: next_pos = job.has_data ? P_DATA_HI : P_CKS_HI;
			P_DATA_LO: next_pos = P_CKS_HI;
			default:   next_pos = 4'(cur_pos + 4'd1);
		endcase
	end

	always_comb begin
		case (cur_pos)
			P_LEN_HI:  nib = job.hdr_len[7:4];
			P_LEN_LO:  nib = job.hdr_len[3:0];
			P_AH_HI:   nib = job.hdr_addr[15:12];
			P_AH_LO:   nib = job.hdr_addr[11:8];
			P_AL_HI:   nib = job.hdr_addr[7:4];
			P_AL_LO:   nib = job.hdr_addr[3:0];
			P_TYPE_LO: nib = {3'b000, job.hdr_eof};
			P_DATA_HI: nib = job.data[7:4];
			P_DATA_LO: nib = job.data[3:0];
			P_CKS_HI:  nib = job.cks[7:4];
			P_CKS_LO:  nib = job.cks[3:0];
			default:   nib = 4'd0;
		endcase
		case (cur_pos)
			P_COLON: ch = CH_COLON;
			P_CR:    ch = CH_CR;
			P_LF:    ch = CH_LF;
			default: ch = hex_char(nib);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			pos_q       <= P_COLON;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				busy_q      <= !last;
				pos_q       <= next_pos;
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload: hold while stalled
	always_ff @(posedge clk) begin
		if (load) begin
			ascii_char      <= ch;
			last_of_run     <= last;
			order_error     <= job.err;
			records_written <= job.shown;
		end
	end

endmodule
`default_nettype wire

// File: sv/intel_hex_record_writer_unit.sv
// ----------------------------------------------------------------------------
// Intel HEX record writer - top level
// Data bytes and record requests in, Intel HEX text out, one character per
// result.
// ----------------------------------------------------------------------------
// Request channel: push/full. A request is taken when push is high and full is
// low; req_type selects data byte, empty record or end-of-file record.
// Result channel: empty/pop. While empty is low, ascii_char and its flags show
// the oldest character; it is taken when pop is high.
// A request is classified and the record state updated in the cycle it is
// taken; it then waits in a four-deep job queue. The sequencer sends one
// character a cycle while the result register is empty or being popped;
// a request passes through the job queue and then the result register. A
// middle data byte gives 2 characters, a one-byte record 15, an empty or
// end-of-file record 13.
// Requests keep being taken while the queue has room, also while a result
// waits; when the receiver stops popping, the result register holds, the
// queue fills and full rises.
// Reset clears the open record, the record count, the queue and the result
// valid flag; the result payload is not reset. No clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none
`include "intel_hex_record_writer_unit_defines.svh"
module intel_hex_record_writer_unit import ihrw_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [1:0]  req_type,
	input  wire logic [15:0] record_address,
	input  wire logic [7:0]  record_length,
	input  wire logic [7:0]  data_byte,
	output logic             empty,
	input  wire logic        pop,
	output logic [6:0]       ascii_char,
	output logic             last_of_run,
	output logic             order_error,
	output logic [15:0]      records_written
);

	logic         accept;
	logic         job_push;
	job_t         front_job, head_job;
	fifo_status_t fifo_st;
	back_status_t back_st;

	assign full   = fifo_st.full;
	assign accept = push && !fifo_st.full;

	ihrw_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.req_type       (req_type),
		.record_address (record_address),
		.record_length  (record_length),
		.data_byte      (data_byte),
		.job_push       (job_push),
		.job            (front_job)
	);

	ihrw_job_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (job_push),
		.wr_job (front_job),
		.rd_en  (back_st.job_pop),
		.rd_job (head_job),
		.status (fifo_st)
	);

	ihrw_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.job_valid       (!fifo_st.empty),
		.job             (head_job),
		.pop             (pop),
		.empty           (empty),
		.ascii_char      (ascii_char),
		.last_of_run     (last_of_run),
		.order_error     (order_error),
		.records_written (records_written),
		.status          (back_st)
	);

	// a job written to an empty queue is visible next cycle
	`IHRW_ASSERT_NEXT(a_fifo_fill, clk, arst_n, job_push && fifo_st.empty, !fifo_st.empty)
	// a job leaves the queue only with its final character
	`IHRW_ASSERT_NOW(a_pop_on_last, clk, arst_n, back_st.job_pop,
		back_st.char_load && back_st.char_last && !fifo_st.empty)
	// occupancy stays within the queue
	`IHRW_ASSERT_NOW(a_fifo_bound, clk, arst_n, 1'b1, fifo_st.count <= JOB_CNT_W'(JOB_DEPTH))

endmodule
`default_nettype wire
